/* rtl/core/kwm_pkg.sv */
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and constants for the k-way record merge unit.
// ----------------------------------------------------------------------------
`default_nettype none

package kwm_pkg;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_BATCH = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [6:0] MAX_BATCH = 7'd64;

  typedef enum logic [1:0] {
    K_LOAD,
    K_BATCH,
    K_CLEAR
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  run;
    logic [63:0] hh;
    logic [15:0] hl;
    logic [6:0]  bmax;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  run;
    logic [9:0]  pos;
    logic [63:0] hh;
    logic [15:0] hl;
    logic        found;
    logic        last;
    logic        ovf;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/kwm_front.sv */
// ----------------------------------------------------------------------------
// kwm_front
// Accepts command words, decodes them, drops unknown ones and queues the rest for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire logic [1:0]    command,
  input  wire logic [2:0]    run_index,
  input  wire logic [63:0]   header_high,
  input  wire logic [15:0]   header_low,
  input  wire logic [6:0]    batch_max,
  output logic               cq_empty,
  output kwm_pkg::cmd_t      cq_word,
  input  wire logic          cq_pop
);
  import kwm_pkg::*;

  cmd_t       q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  cmd_t       dec;
  logic       keep;
  logic       wr;

  always_comb begin
    dec.run  = run_index;
    dec.hh   = header_high;
    dec.hl   = header_low;
    dec.bmax = (batch_max == 7'd0) ? 7'd1 :
               (batch_max > MAX_BATCH) ? MAX_BATCH : batch_max;
    keep     = 1'b1;
    dec.kind = K_LOAD;
    unique case (command)
      CMD_LOAD:  dec.kind = K_LOAD;
      CMD_BATCH: dec.kind = K_BATCH;
      CMD_CLEAR: dec.kind = K_CLEAR;
      default:   keep = 1'b0;
    endcase
  end

  assign full     = (cnt == 2'd2);
  assign cq_empty = (cnt == 2'd0);
  assign cq_word  = q[rp];
  assign wr       = push && !full && keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) begin
        q[wp] <= dec;
        wp    <= ~wp;
      end
      if (cq_pop) rp <= ~rp;
      cnt <= cnt + {1'b0, wr} - {1'b0, cq_pop};
    end
  end

endmodule

`default_nettype wire

/* rtl/core/kwm_out_fifo.sv */
// ----------------------------------------------------------------------------
// kwm_out_fifo
// Four-entry result queue between the back end and the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_out_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  wire kwm_pkg::res_t wr_word,
  output logic               wr_full,
  output logic               empty,
  input  wire logic          pop,
  output kwm_pkg::res_t      rd_word
);
  import kwm_pkg::*;

  res_t       q [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic       do_wr, do_rd;

  assign wr_full = (cnt == 3'd4);
  assign empty   = (cnt == 3'd0);
  assign rd_word = q[rp];
  assign do_wr   = wr && !wr_full;
  assign do_rd   = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 2'd0;
      rp  <= 2'd0;
      cnt <= 3'd0;
    end else begin
      if (do_wr) begin
        q[wp] <= wr_word;
        wp    <= wp + 2'd1;
      end
      if (do_rd) rp <= rp + 2'd1;
      cnt <= cnt + {2'b0, do_wr} - {2'b0, do_rd};
    end
  end

endmodule

`default_nettype wire

/* rtl/core/kwm_back.sv */
// ----------------------------------------------------------------------------
// kwm_back
// Executes loads, clears and merge batches; owns the run store and pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_back #(
  parameter int WAYS         = 8,
  parameter int RUN_DEPTH    = 1024,
  parameter int HEADER_BYTES = 10
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cq_empty,
  input  wire kwm_pkg::cmd_t cq_word,
  output logic               cq_pop,
  input  wire logic          oq_full,
  output logic               oq_wr,
  output kwm_pkg::res_t      oq_word
);
  import kwm_pkg::*;

  localparam int WIDX  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int FW    = $clog2(RUN_DEPTH + 1);
  localparam int AW    = $clog2(WAYS * RUN_DEPTH);
  localparam logic [63:0] MH = (HEADER_BYTES >= 8) ? {64{1'b1}} :
                               ({64{1'b1}} << (8 * (8 - HEADER_BYTES)));
  localparam logic [15:0] ML = (HEADER_BYTES <= 8) ? 16'h0000 :
                               (16'hFFFF << (8 * (10 - HEADER_BYTES)));

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_ISSUE, S_DRAIN, S_EMIT, S_FLUSH
  } state_t;

  state_t          state;
  cmd_t            cmd;
  logic [FW-1:0]   fill [WAYS];
  logic [FW-1:0]   head [WAYS];
  logic [63:0]     mem_h [WAYS * RUN_DEPTH];
  logic [15:0]     mem_l [WAYS * RUN_DEPTH];
  logic [63:0]     mem_hh;
  logic [15:0]     mem_hl;
  logic [WIDX-1:0] sc;
  logic [6:0]      cnt;
  logic            p_act, p_v;
  logic [WIDX-1:0] p_way;
  logic [FW-1:0]   p_pos;
  logic            best_v;
  logic [WIDX-1:0] best_way;
  logic [FW-1:0]   best_pos;
  logic [63:0]     best_hh;
  logic [15:0]     best_hl;
  logic            pend_v;
  logic [WIDX-1:0] pend_way;
  logic [FW-1:0]   pend_pos;
  logic [63:0]     pend_hh;
  logic [15:0]     pend_hl;
  logic            rd_ne;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic [WIDX-1:0] lway;
  logic            bad;
  logic            mem_we;
  logic            take;
  res_t            pend_res;

  assign rd_ne   = head[sc] < fill[sc];
  assign rd_addr = rd_ne ? AW'(AW'(sc) * AW'(RUN_DEPTH)) + AW'(head[sc]) : '0;
  assign lway    = WIDX'(cmd.run);
  assign bad     = (32'(cmd.run) >= WAYS) || (fill[lway] >= FW'(RUN_DEPTH));
  assign wr_addr = AW'(AW'(lway) * AW'(RUN_DEPTH)) + AW'(fill[lway]);
  assign mem_we  = (state == S_LOAD) && !oq_full && !bad;
  assign take    = p_act && p_v &&
                   (!best_v || ({mem_hh & MH, mem_hl & ML} < {best_hh & MH, best_hl & ML}));
  assign cq_pop  = (state == S_IDLE) && !cq_empty;

  always_comb begin
    pend_res.run   = 3'(pend_way);
    pend_res.pos   = 10'(pend_pos);
    pend_res.hh    = pend_hh;
    pend_res.hl    = pend_hl;
    pend_res.found = 1'b1;
    pend_res.last  = 1'b0;
    pend_res.ovf   = 1'b0;
    oq_wr   = 1'b0;
    oq_word = '0;
    unique case (state)
      S_LOAD: begin
        oq_wr        = !oq_full;
        oq_word.run  = cmd.run;
        oq_word.pos  = bad ? 10'd0 : 10'(fill[lway]);
        oq_word.last = 1'b1;
        oq_word.ovf  = bad;
      end
      S_EMIT: begin
        if (best_v) begin
          oq_wr   = pend_v && !oq_full;
          oq_word = pend_res;
        end else begin
          oq_wr = !oq_full;
          if (pend_v) oq_word = pend_res;
          oq_word.last = 1'b1;
        end
      end
      S_FLUSH: begin
        oq_wr        = !oq_full;
        oq_word      = pend_res;
        oq_word.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_h[wr_addr] <= cmd.hh;
      mem_l[wr_addr] <= cmd.hl;
    end
    mem_hh <= mem_h[rd_addr];
    mem_hl <= mem_l[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      p_act  <= 1'b0;
      best_v <= 1'b0;
      pend_v <= 1'b0;
      cnt    <= 7'd0;
      sc     <= '0;
      for (int i = 0; i < WAYS; i++) begin
        fill[i] <= '0;
        head[i] <= '0;
      end
    end else begin
      p_act <= (state == S_ISSUE);
      p_v   <= rd_ne;
      p_way <= sc;
      p_pos <= head[sc];
      if (take) begin
        best_v   <= 1'b1;
        best_way <= p_way;
        best_pos <= p_pos;
        best_hh  <= mem_hh;
        best_hl  <= mem_hl;
      end
      unique case (state)
        S_IDLE: begin
          if (!cq_empty) begin
            cmd <= cq_word;
            unique case (cq_word.kind)
              K_LOAD:  state <= S_LOAD;
              K_BATCH: begin
                sc     <= '0;
                best_v <= 1'b0;
                pend_v <= 1'b0;
                cnt    <= 7'd0;
                state  <= S_ISSUE;
              end
              K_CLEAR: begin
                for (int i = 0; i < WAYS; i++) begin
                  fill[i] <= '0;
                  head[i] <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_LOAD: begin
          if (!oq_full) begin
            if (!bad) fill[lway] <= fill[lway] + FW'(1);
            state <= S_IDLE;
          end
        end
        S_ISSUE: begin
          sc <= sc + WIDX'(1);
          if (sc == WIDX'(WAYS - 1)) state <= S_DRAIN;
        end
        S_DRAIN: state <= S_EMIT;
        S_EMIT: begin
          if (best_v) begin
            if (pend_v) begin
              if (!oq_full) pend_v <= 1'b0;
            end else begin
              pend_v   <= 1'b1;
              pend_way <= best_way;
              pend_pos <= best_pos;
              pend_hh  <= best_hh;
              pend_hl  <= best_hl;
              head[best_way] <= head[best_way] + FW'(1);
              cnt <= cnt + 7'd1;
              if (cnt + 7'd1 == cmd.bmax) begin
                state <= S_FLUSH;
              end else begin
                sc     <= '0;
                best_v <= 1'b0;
                state  <= S_ISSUE;
              end
            end
          end else if (!oq_full) begin
            pend_v <= 1'b0;
            state  <= S_IDLE;
          end
        end
        S_FLUSH: begin
          if (!oq_full) begin
            pend_v <= 1'b0;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && cmd.kind == K_BATCH) |-> cnt <= cmd.bmax)
    else $error("batch count above limit");
  a_pend_idle: assert property (@(posedge clk) disable iff (rst)
    pend_v |-> (state != S_IDLE && state != S_LOAD))
    else $error("pending word outside batch");
  a_load_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD && !oq_full) |=> state == S_IDLE)
    else $error("load did not finish");
  a_best_src: assert property (@(posedge clk) disable iff (rst)
    $rose(best_v) |-> $past(p_act))
    else $error("best set without compare");
`endif

endmodule

`default_nettype wire

/* rtl/core/kway_record_merge_unit.sv */
// ----------------------------------------------------------------------------
// kway_record_merge_unit
// Merges up to WAYS sorted runs of 80-bit record headers into one stream.
// ----------------------------------------------------------------------------
// A load word appends a header to a run and returns one word (an overflow
// word if the run is full or out of range). A batch word returns up to batch_max
// merged records (0 counts as 1, above 64 as 64); each record is chosen by a
// scan of the run heads through the single read port of the run store. No
// clearing pass runs after reset.
`default_nettype none

module kway_record_merge_unit #(
  parameter int WAYS         = 8,
  parameter int RUN_DEPTH    = 1024,
  parameter int HEADER_BYTES = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  command,
  input  wire logic [2:0]  run_index,
  input  wire logic [63:0] header_high,
  input  wire logic [15:0] header_low,
  input  wire logic [6:0]  batch_max,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       out_run,
  output logic [9:0]       out_position,
  output logic [63:0]      out_header_high,
  output logic [15:0]      out_header_low,
  output logic             found,
  output logic             last,
  output logic             overflow
);
  import kwm_pkg::*;

  logic cq_empty, cq_pop, oq_full, oq_wr;
  cmd_t cq_word;
  res_t oq_word, rd_word;

  kwm_front u_front (
    .clk, .rst, .push, .full, .command, .run_index, .header_high,
    .header_low, .batch_max, .cq_empty, .cq_word, .cq_pop
  );

  kwm_back #(
    .WAYS(WAYS), .RUN_DEPTH(RUN_DEPTH), .HEADER_BYTES(HEADER_BYTES)
  ) u_back (
    .clk, .rst, .cq_empty, .cq_word, .cq_pop, .oq_full, .oq_wr, .oq_word
  );

  kwm_out_fifo u_out (
    .clk, .rst, .wr(oq_wr), .wr_word(oq_word), .wr_full(oq_full),
    .empty, .pop, .rd_word
  );

  assign out_run         = rd_word.run;
  assign out_position    = rd_word.pos;
  assign out_header_high = rd_word.hh;
  assign out_header_low  = rd_word.hl;
  assign found           = rd_word.found;
  assign last            = rd_word.last;
  assign overflow        = rd_word.ovf;

endmodule

`default_nettype wire

/* bench/kway_record_merge_unit_test.sv */
// ----------------------------------------------------------------------------
// kway_record_merge_unit_test
// Self-checking bench for the k-way record merge unit: a directed table,
// a run filled to overflow, then random load/batch/clear traffic checked
// word by word against a merge predictor, under random push/pop idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kway_record_merge_unit_test;
  import kwm_pkg::*;

  localparam int NWAYS = 8;
  localparam int DEPTH = 1024;
  localparam logic [1:0] CMD_NONE = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  command = CMD_LOAD;
  logic [2:0]  run_index = '0;
  logic [63:0] header_high = '0;
  logic [15:0] header_low = '0;
  logic [6:0]  batch_max = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  out_run;
  logic [9:0]  out_position;
  logic [63:0] out_header_high;
  logic [15:0] out_header_low;
  logic        found;
  logic        last;
  logic        overflow;

  kway_record_merge_unit dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .command(command),
    .run_index(run_index), .header_high(header_high), .header_low(header_low),
    .batch_max(batch_max), .empty(empty), .pop(pop), .out_run(out_run),
    .out_position(out_position), .out_header_high(out_header_high),
    .out_header_low(out_header_low), .found(found), .last(last),
    .overflow(overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [79:0] hdr_mem [NWAYS][DEPTH];
  int          fill_cnt [NWAYS];
  int          head_cnt [NWAYS];
  res_t        pending_words [$];
  int          errors = 0;
  int          phase = 2;       // 0: sender light, rx heavy; 1: swapped; 2: none
  bit          hold_req = 1'b0;

  function automatic res_t mk_res(logic [2:0] r, logic [9:0] p, logic [79:0] h,
                                  logic f, logic l, logic o);
    res_t w;
    w.run = r; w.pos = p; w.hh = h[79:16]; w.hl = h[15:0];
    w.found = f; w.last = l; w.ovf = o;
    return w;
  endfunction

  task automatic merge_predict(logic [1:0] cmd, logic [2:0] run, logic [79:0] hdr,
                               logic [6:0] bmax, bit quiet);
    int lim, cnt, best;
    res_t w;
    case (cmd)
      CMD_LOAD: begin
        if (fill_cnt[run] >= DEPTH) begin
          w = mk_res(run, '0, '0, 1'b0, 1'b1, 1'b1);
        end else begin
          hdr_mem[run][fill_cnt[run]] = hdr;
          w = mk_res(run, 10'(fill_cnt[run]), '0, 1'b0, 1'b1, 1'b0);
          fill_cnt[run]++;
        end
        if (!quiet) pending_words.push_back(w);
      end
      CMD_BATCH: begin
        lim = (bmax == 0) ? 1 : (bmax > MAX_BATCH) ? MAX_BATCH : bmax;
        cnt = 0;
        while (cnt < lim) begin
          best = -1;
          for (int r = 0; r < NWAYS; r++) begin
            if (head_cnt[r] < fill_cnt[r]) begin
              if (best < 0) best = r;
              else if (hdr_mem[r][head_cnt[r]] < hdr_mem[best][head_cnt[best]]) best = r;
            end
          end
          if (best < 0) break;
          w = mk_res(3'(best), 10'(head_cnt[best]), hdr_mem[best][head_cnt[best]],
                     1'b1, 1'b0, 1'b0);
          head_cnt[best]++;
          cnt++;
          if (!quiet) pending_words.push_back(w);
        end
        if (!quiet) begin
          if (cnt == 0) pending_words.push_back(mk_res('0, '0, '0, 1'b0, 1'b1, 1'b0));
          else pending_words[$].last = 1'b1;
        end
      end
      CMD_CLEAR: begin
        for (int r = 0; r < NWAYS; r++) begin
          fill_cnt[r] = 0;
          head_cnt[r] = 0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_word(logic [1:0] cmd, logic [2:0] run, logic [79:0] hdr,
                           logic [6:0] bmax, bit quiet);
    int idle_pct;
    idle_pct = (phase == 0) ? 14 : (phase == 1) ? 76 : 0;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    command = cmd;
    run_index = run;
    header_high = hdr[79:16];
    header_low = hdr[15:0];
    batch_max = bmax;
    do @(posedge clk); while (full);
    merge_predict(cmd, run, hdr, bmax, quiet);
  endtask

  task automatic drop_push;
    @(negedge clk);
    push = 1'b0;
  endtask

  // receiver
  initial begin
    int hold_left, idle_pct;
    res_t e;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      idle_pct = (phase == 0) ? 76 : (phase == 1) ? 14 : 0;
      if (hold_left > 0) begin
        hold_left--;
        pop = 1'b0;
      end else begin
        pop = ($urandom_range(99) >= idle_pct);
      end
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (pending_words.size() == 0) begin
          $display("%0t unexpected word run=%0d pos=%0d", $time, out_run, out_position);
          errors++;
        end else begin
          e = pending_words.pop_front();
          if (out_run !== e.run || out_position !== e.pos || out_header_high !== e.hh ||
              out_header_low !== e.hl || found !== e.found || last !== e.last ||
              overflow !== e.ovf) begin
            $display("%0t mismatch exp run=%0d pos=%0d h=%h_%h f=%b l=%b o=%b",
                     $time, e.run, e.pos, e.hh, e.hl, e.found, e.last, e.ovf);
            $display("%0t          got run=%0d pos=%0d h=%h_%h f=%b l=%b o=%b",
                     $time, out_run, out_position, out_header_high, out_header_low,
                     found, last, overflow);
            errors++;
          end
        end
      end
    end
  end

  typedef struct {
    logic [1:0]  cmd;
    logic [2:0]  run;
    logic [79:0] hdr;
    logic [6:0]  bmax;
    bit          typed;
    res_t        want;
  } stim_row_t;

  function automatic logic [79:0] rand_hdr;
    case ($urandom_range(3))
      0: return {$urandom, $urandom, 16'($urandom)};
      1: return {64'd0, 16'($urandom_range(3))};
      2: return {64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF};
      default: return {32'd0, 32'($urandom_range(5)), 16'($urandom_range(1))};
    endcase
  endfunction

  initial begin
    stim_row_t tbl [$];
    int pick;
    logic [6:0] bm;
    for (int r = 0; r < NWAYS; r++) begin
      fill_cnt[r] = 0;
      head_cnt[r] = 0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rows
    tbl.push_back('{CMD_BATCH, 3'd0, 80'd0, 7'd5, 1,
                    mk_res(3'd0, 10'd0, 80'd0, 1'b0, 1'b1, 1'b0)});
    tbl.push_back('{CMD_LOAD, 3'd0, '1, 7'd0, 1,
                    mk_res(3'd0, 10'd0, 80'd0, 1'b0, 1'b1, 1'b0)});
    tbl.push_back('{CMD_LOAD, 3'd7, 80'd0, 7'd0, 1,
                    mk_res(3'd7, 10'd0, 80'd0, 1'b0, 1'b1, 1'b0)});
    tbl.push_back('{CMD_LOAD, 3'd3, 80'd5, 7'd0, 1,
                    mk_res(3'd3, 10'd0, 80'd0, 1'b0, 1'b1, 1'b0)});
    tbl.push_back('{CMD_LOAD, 3'd5, 80'd5, 7'd0, 0, '0});
    tbl.push_back('{CMD_LOAD, 3'd7, 80'd5, 7'd0, 0, '0});
    tbl.push_back('{CMD_LOAD, 3'd1, {64'd1, 16'd0}, 7'd0, 0, '0});
    tbl.push_back('{CMD_LOAD, 3'd2, {64'd0, 16'hFFFF}, 7'd0, 0, '0});
    tbl.push_back('{CMD_BATCH, 3'd0, 80'd0, 7'd0, 0, '0});
    tbl.push_back('{CMD_BATCH, 3'd0, 80'd0, 7'd2, 0, '0});
    tbl.push_back('{CMD_NONE, 3'd4, '1, 7'd9, 0, '0});
    tbl.push_back('{CMD_LOAD, 3'd7, 80'd1, 7'd0, 0, '0});
    tbl.push_back('{CMD_BATCH, 3'd0, 80'd0, 7'd127, 0, '0});
    tbl.push_back('{CMD_BATCH, 3'd0, 80'd0, 7'd64, 1,
                    mk_res(3'd0, 10'd0, 80'd0, 1'b0, 1'b1, 1'b0)});
    tbl.push_back('{CMD_LOAD, 3'd4, 80'd9, 7'd0, 0, '0});
    tbl.push_back('{CMD_CLEAR, 3'd0, 80'd0, 7'd0, 0, '0});
    tbl.push_back('{CMD_BATCH, 3'd0, 80'd0, 7'd1, 1,
                    mk_res(3'd0, 10'd0, 80'd0, 1'b0, 1'b1, 1'b0)});
    tbl.push_back('{CMD_LOAD, 3'd6, 80'd3, 7'd0, 1,
                    mk_res(3'd6, 10'd0, 80'd0, 1'b0, 1'b1, 1'b0)});
    tbl.push_back('{CMD_BATCH, 3'd0, 80'd0, 7'd65, 0, '0});
    foreach (tbl[i]) begin
      send_word(tbl[i].cmd, tbl[i].run, tbl[i].hdr, tbl[i].bmax, tbl[i].typed);
      if (tbl[i].typed && tbl[i].cmd != CMD_CLEAR && tbl[i].cmd != CMD_NONE)
        pending_words.push_back(tbl[i].want);
    end

    // fill one run past its depth; receiver stalls at the start
    send_word(CMD_CLEAR, 3'd0, 80'd0, 7'd0, 0);
    hold_req = 1'b1;
    for (int k = 0; k <= DEPTH; k++)
      send_word(CMD_LOAD, 3'd2, {54'd0, 10'(k), 16'($urandom)}, 7'd0, 0);
    send_word(CMD_LOAD, 3'd2, '1, 7'd0, 0);
    send_word(CMD_BATCH, 3'd0, 80'd0, 7'd64, 0);
    send_word(CMD_CLEAR, 3'd0, 80'd0, 7'd0, 0);

    // random traffic
    for (int i = 0; i < 420; i++) begin
      phase = (i < 140) ? 0 : (i < 280) ? 1 : 2;
      pick = $urandom_range(99);
      if (pick < 60) begin
        send_word(CMD_LOAD, 3'($urandom_range(7)), rand_hdr(), 7'($urandom), 0);
      end else if (pick < 90) begin
        case ($urandom_range(5))
          0: bm = 7'd0;
          1: bm = 7'($urandom_range(127, 65));
          2: bm = 7'd64;
          default: bm = 7'($urandom_range(16, 1));
        endcase
        send_word(CMD_BATCH, 3'($urandom_range(7)), rand_hdr(), bm, 0);
      end else if (pick < 95) begin
        send_word(CMD_CLEAR, 3'($urandom_range(7)), rand_hdr(), 7'($urandom), 0);
      end else begin
        send_word(CMD_NONE, 3'($urandom_range(7)), rand_hdr(), 7'($urandom), 0);
      end
    end
    drop_push();

    while (pending_words.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
